### rtl/mvm_pkg.sv
// Shared constants, codes and types for the matrix-vector multiply core.
`default_nettype none
package mvm_pkg;

	// Problem size limits
	localparam int COLS_MAX = 1024;
	localparam int ROWS_MAX = 65536;

	// Widths of indexes, counts and data
	localparam int COL_W     = $clog2(COLS_MAX);
	localparam int COL_CNT_W = $clog2(COLS_MAX + 1);
	localparam int ROW_W     = $clog2(ROWS_MAX);
	localparam int ROW_CNT_W = $clog2(ROWS_MAX + 1);
	localparam int VAL_W     = 16;
	localparam int PROD_W    = 2 * VAL_W;
	localparam int SUM_W     = 48;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = ROW_CNT_W;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ROWS = CFG_IDX_W'(1);

	// Item kinds on the input tuser
	localparam logic ACT_LOAD_VEC = 1'b0;
	localparam logic ACT_MATRIX   = 1'b1;

	// Bookkeeping that travels with a matrix item down the pipeline
	typedef struct packed {
		logic             last_col;
		logic [ROW_W-1:0] row;
		logic             last_row;
	} mvm_tag_t;

endpackage
`default_nettype wire

### rtl/mvm_vec_store.sv
// Vector store: one write port, one read port with registered read data.
`default_nettype none
module mvm_vec_store (
	input  wire                             clk,
	input  wire                             we,
	input  wire  [mvm_pkg::COL_W-1:0]       waddr,
	input  wire  [mvm_pkg::VAL_W-1:0]       wdata,
	input  wire                             re,
	input  wire  [mvm_pkg::COL_W-1:0]       raddr,
	output logic [mvm_pkg::VAL_W-1:0]       rdata
);

	logic [mvm_pkg::VAL_W-1:0] mem_q [mvm_pkg::COLS_MAX];

	// Write an element
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read an element; hold the last read while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### rtl/mvm_mac.sv
// Multiply stage, saturating accumulator and result output register.
`default_nettype none
module mvm_mac (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	input  wire  [mvm_pkg::VAL_W-1:0]           in_value,
	input  wire  [mvm_pkg::VAL_W-1:0]           in_coef,
	input  wire  mvm_pkg::mvm_tag_t             in_tag,
	output logic                                ready,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [63:0]                         m_tdata,   // dot_value[47:0], row_index[63:48]
	output logic                                m_tlast    // last_row
);

	logic                                valid_s2;
	logic signed [mvm_pkg::PROD_W-1:0]   product_s2;
	mvm_pkg::mvm_tag_t                   tag_s2;
	logic signed [mvm_pkg::SUM_W-1:0]    acc_q;
	logic                                out_valid_q;
	logic [mvm_pkg::SUM_W-1:0]           out_dot_q;
	logic [mvm_pkg::ROW_W-1:0]           out_row_q;
	logic                                out_last_q;
	logic signed [mvm_pkg::SUM_W:0]      sum_wide;
	logic signed [mvm_pkg::SUM_W-1:0]    sum_sat;
	logic                                advance;
	logic                                emit;

	// Stall only when a result must be written and the output register is still full
	assign advance = !(valid_s2 && tag_s2.last_col && out_valid_q && !m_tready);
	assign ready   = advance;
	assign emit    = advance && valid_s2 && tag_s2.last_col;

	// Add with one guard bit, then clamp to the 48-bit range
	always_comb begin
		sum_wide = {acc_q[mvm_pkg::SUM_W-1], acc_q}
			+ (mvm_pkg::SUM_W+1)'(product_s2);
		if (sum_wide[mvm_pkg::SUM_W] != sum_wide[mvm_pkg::SUM_W-1]) begin
			sum_sat = sum_wide[mvm_pkg::SUM_W]
				? {1'b1, {(mvm_pkg::SUM_W-1){1'b0}}}
				: {1'b0, {(mvm_pkg::SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[mvm_pkg::SUM_W-1:0];
		end
	end

	// Multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			product_s2 <= signed'(in_value) * signed'(in_coef);
			tag_s2     <= in_tag;
		end
	end

	// Accumulate; clear after the last column of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (advance && valid_s2) begin
			acc_q <= tag_s2.last_col ? '0 : sum_sat;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_dot_q  <= sum_sat;
			out_row_q  <= tag_s2.row;
			out_last_q <= tag_s2.last_row;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_row_q, out_dot_q};
	assign m_tlast  = out_last_q;

	// A stall always has a waiting result behind it
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |-> (out_valid_q && valid_s2 && tag_s2.last_col))
		else $error("mac stalled without a pending result");

	// The sum restarts at zero after each row
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (acc_q == '0))
		else $error("accumulator not cleared after a row");

	// A new result is shown in the cycle after it is written
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("result not presented");

endmodule
`default_nettype wire

### rtl/matrix_vector_multiply_core.sv
// Top level: configuration, column/row/load counters, vector store and MAC pipeline.
// A row result reaches m_tdata after the edge that accepts the row's last matrix item,
// by way of the store read, the multiply and the accumulate into the output register.
// Throughput: one item per cycle, loads and matrix items alike; the input stalls only
// while a row result waits in the output register and the next row result is due.
// Reset (arst_n low): counters and sum clear, cols_cfg_q = 1024, rows_cfg_q = 65536;
// the vector store keeps no reset and must be loaded before it is read.
`default_nettype none
module matrix_vector_multiply_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [mvm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [mvm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire  [15:0]                         s_tdata,   // value[15:0]
	input  wire                                 s_tuser,   // action
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [63:0]                         m_tdata,   // dot_value[47:0], row_index[63:48]
	output logic                                m_tlast    // last_row
);

	logic [mvm_pkg::COL_CNT_W-1:0] cols_cfg_q;
	logic [mvm_pkg::ROW_CNT_W-1:0] rows_cfg_q;
	logic [mvm_pkg::COL_CNT_W-1:0] cols_eff;
	logic [mvm_pkg::ROW_CNT_W-1:0] rows_eff;
	logic [mvm_pkg::COL_W-1:0]     lp_q;
	logic [mvm_pkg::COL_W-1:0]     col_q;
	logic [mvm_pkg::ROW_W-1:0]     row_q;
	logic [mvm_pkg::COL_CNT_W-1:0] lp_inc;
	logic [mvm_pkg::COL_CNT_W-1:0] col_inc;
	logic [mvm_pkg::ROW_CNT_W-1:0] row_inc;
	logic                          lp_wrap;
	logic                          col_last;
	logic                          row_last;
	logic                          accept;
	logic                          load_acc;
	logic                          mat_acc;
	logic                          mac_ready;
	logic                          valid_s1;
	logic [mvm_pkg::VAL_W-1:0]     value_s1;
	mvm_pkg::mvm_tag_t             tag_s1;
	logic [mvm_pkg::VAL_W-1:0]     coef_s1;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= mvm_pkg::COL_CNT_W'(mvm_pkg::COLS_MAX);
			rows_cfg_q <= mvm_pkg::ROW_CNT_W'(mvm_pkg::ROWS_MAX);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mvm_pkg::CFG_COLS: cols_cfg_q <= cfg_data[mvm_pkg::COL_CNT_W-1:0];
				mvm_pkg::CFG_ROWS: rows_cfg_q <= cfg_data[mvm_pkg::ROW_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp configured sizes to the supported range
	always_comb begin
		if (cols_cfg_q == '0) begin
			cols_eff = mvm_pkg::COL_CNT_W'(1);
		end else if (cols_cfg_q > mvm_pkg::COL_CNT_W'(mvm_pkg::COLS_MAX)) begin
			cols_eff = mvm_pkg::COL_CNT_W'(mvm_pkg::COLS_MAX);
		end else begin
			cols_eff = cols_cfg_q;
		end
		if (rows_cfg_q == '0) begin
			rows_eff = mvm_pkg::ROW_CNT_W'(1);
		end else if (rows_cfg_q > mvm_pkg::ROW_CNT_W'(mvm_pkg::ROWS_MAX)) begin
			rows_eff = mvm_pkg::ROW_CNT_W'(mvm_pkg::ROWS_MAX);
		end else begin
			rows_eff = rows_cfg_q;
		end
	end

	// Handshake and item kind
	assign s_tready = mac_ready;
	assign accept   = s_tvalid && s_tready;
	assign load_acc = accept && (s_tuser == mvm_pkg::ACT_LOAD_VEC);
	assign mat_acc  = accept && (s_tuser == mvm_pkg::ACT_MATRIX);

	// End-of-run tests for the counters
	assign lp_inc   = mvm_pkg::COL_CNT_W'(lp_q) + mvm_pkg::COL_CNT_W'(1);
	assign col_inc  = mvm_pkg::COL_CNT_W'(col_q) + mvm_pkg::COL_CNT_W'(1);
	assign row_inc  = mvm_pkg::ROW_CNT_W'(row_q) + mvm_pkg::ROW_CNT_W'(1);
	assign lp_wrap  = (lp_inc >= cols_eff);
	assign col_last = (col_inc >= cols_eff);
	assign row_last = (row_inc >= rows_eff);

	// Advance load pointer, column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= '0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (load_acc) begin
				lp_q <= lp_wrap ? '0 : lp_inc[mvm_pkg::COL_W-1:0];
			end
			if (mat_acc) begin
				col_q <= col_last ? '0 : col_inc[mvm_pkg::COL_W-1:0];
				if (col_last) begin
					row_q <= row_last ? '0 : row_inc[mvm_pkg::ROW_W-1:0];
				end
			end
		end
	end

	// Vector store: loads write, matrix items read their column
	mvm_vec_store u_store (
		.clk   (clk),
		.we    (load_acc),
		.waddr (lp_q),
		.wdata (s_tdata[mvm_pkg::VAL_W-1:0]),
		.re    (mat_acc),
		.raddr (col_q),
		.rdata (coef_s1)
	);

	// Read stage: hold item alongside the store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (mac_ready) begin
			valid_s1 <= mat_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_acc) begin
			value_s1        <= s_tdata[mvm_pkg::VAL_W-1:0];
			tag_s1.last_col <= col_last;
			tag_s1.row      <= row_q;
			tag_s1.last_row <= row_last;
		end
	end

	mvm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_s1),
		.in_value (value_s1),
		.in_coef  (coef_s1),
		.in_tag   (tag_s1),
		.ready    (mac_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Input backpressure only while a result is waiting
	a_stall_only_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// Last column of the last row restarts the matrix
	a_matrix_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_acc && col_last && row_last) |=> (col_q == '0 && row_q == '0))
		else $error("counters not restarted after last row");

	// Load pointer wraps at the end of the vector
	a_load_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(load_acc && lp_wrap) |=> (lp_q == '0))
		else $error("load pointer did not wrap");

endmodule
`default_nettype wire
